[rtl/tlg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlg_pkg
// Shared types and codes for the toroidal life grid.
// ----------------------------------------------------------------------------
package tlg_pkg;

	localparam logic [2:0] KIND_TICK   = 3'd0;
	localparam logic [2:0] KIND_CLEAR  = 3'd1;
	localparam logic [2:0] KIND_TOGGLE = 3'd2;
	localparam logic [2:0] KIND_CROSS  = 3'd3;
	localparam logic [2:0] KIND_READ   = 3'd4;

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	localparam logic [6:0] DIM_RESET = 7'd20;

	typedef struct packed {
		logic [2:0] kind;
		logic [5:0] col;
		logic [5:0] row;
	} cmd_t;

	typedef struct packed {
		logic cell_alive;
		logic bad_coord;
	} result_t;

endpackage

[rtl/tlg_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlg_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module tlg_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/toroidal_life_grid_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toroidal_life_grid_top
// Game of Life (B3/S23) on a wrapped grid held one row per memory word.
// ----------------------------------------------------------------------------
// A command word is taken on start while busy is low. Its single result word
// appears on result with done high for one cycle; the receiver cannot stall.
// Width and height are set through cfg_we, cfg_idx and cfg_data; the user
// writes them only while idle, which the block itself does not enforce. The
// grid lives in one memory of MAX_DIM rows of MAX_DIM bits, so row-wide work
// costs one memory access per row; that memory port sets the timing.
// Work per command: read and toggle touch one row, a bad coordinate or an
// unused kind none; clear walks every row of the height; diagonal cross walks
// min(width, height) rows; a generation tick prefetches the last row and then
// the first row, then handles one row per cycle, rewritten in place.
// One command is in work at a time; a new one may start in the cycle of done.
// After reset a clearing pass zeroes all MAX_DIM rows of the grid with busy
// high; configuration writes are taken during it.
// ----------------------------------------------------------------------------
module toroidal_life_grid_top #(
	parameter int MAX_DIM = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  tlg_pkg::cmd_t       cmd,
	output logic                done,
	output tlg_pkg::result_t    result,
	input  logic                cfg_we,
	input  logic                cfg_idx,
	input  logic [6:0]          cfg_data
);

	localparam int AW = $clog2(MAX_DIM);
	localparam int DW = $clog2(MAX_DIM + 1);

	typedef enum logic [5:0] {
		S_INIT   = 6'b000001,
		S_IDLE   = 6'b000010,
		S_RWAIT  = 6'b000100,
		S_TLAST  = 6'b001000,
		S_TFIRST = 6'b010000,
		S_TROW   = 6'b100000
	} state_t;

	state_t state_q;
	logic [6:0] cfg_w_q, cfg_h_q;
	logic [DW-1:0] w_eff, h_eff, s_eff;
	logic [DW-1:0] w_q, h_q;
	logic [2:0] kind_q;
	logic [AW-1:0] col_q, r_q, end_q;
	logic [MAX_DIM-1:0] last_q, first_q, prev_q, cur_q;
	logic [MAX_DIM-1:0] rdata, wdata, mod_row, new_row, above, below;
	logic [AW-1:0] raddr, waddr;
	logic we;
	logic done_q;
	tlg_pkg::result_t result_q;
	logic bad_in;

	always_comb begin
		if (cfg_w_q == 7'd0) begin
			w_eff = DW'(1);
		end else if (int'(cfg_w_q) > MAX_DIM) begin
			w_eff = DW'(MAX_DIM);
		end else begin
			w_eff = DW'(cfg_w_q);
		end
		if (cfg_h_q == 7'd0) begin
			h_eff = DW'(1);
		end else if (int'(cfg_h_q) > MAX_DIM) begin
			h_eff = DW'(MAX_DIM);
		end else begin
			h_eff = DW'(cfg_h_q);
		end
		s_eff = (w_eff < h_eff) ? w_eff : h_eff;
		bad_in = (int'(cmd.col) >= int'(w_eff)) || (int'(cmd.row) >= int'(h_eff));
	end

	// Row operations other than the tick.
	always_comb begin
		for (int c = 0; c < MAX_DIM; c++) begin
			mod_row[c] = rdata[c];
			if (c < int'(w_q)) begin
				case (kind_q)
					tlg_pkg::KIND_CLEAR: begin
						mod_row[c] = 1'b0;
					end
					tlg_pkg::KIND_CROSS: begin
						mod_row[c] = rdata[c] ^ ((c == int'(r_q)) ^ (c == int'(end_q - r_q)));
					end
					tlg_pkg::KIND_TOGGLE: begin
						mod_row[c] = rdata[c] ^ (c == int'(col_q));
					end
					default: begin
						mod_row[c] = rdata[c];
					end
				endcase
			end
		end
	end

	// Next generation of one row from its wrapped neighbours.
	always_comb begin
		logic [AW-1:0] lc, rc;
		logic [3:0] n;
		above = (r_q == '0) ? last_q : prev_q;
		below = (r_q == AW'(h_q - DW'(1))) ? first_q : rdata;
		for (int c = 0; c < MAX_DIM; c++) begin
			lc = (c == 0) ? AW'(w_q - DW'(1)) : AW'(c - 1);
			rc = (c + 1 >= int'(w_q)) ? '0 : AW'(c + 1);
			n = 4'(above[lc]) + 4'(above[c]) + 4'(above[rc]) + 4'(cur_q[lc])
				+ 4'(cur_q[rc]) + 4'(below[lc]) + 4'(below[c]) + 4'(below[rc]);
			if (c < int'(w_q)) begin
				new_row[c] = (n == 4'd3) || ((n == 4'd2) && cur_q[c]);
			end else begin
				new_row[c] = cur_q[c];
			end
		end
	end

	always_comb begin
		raddr = r_q + AW'(1);
		we    = 1'b0;
		waddr = r_q;
		wdata = mod_row;
		case (state_q)
			S_INIT: begin
				we    = 1'b1;
				wdata = '0;
			end
			S_IDLE: begin
				case (cmd.kind)
					tlg_pkg::KIND_TICK: raddr = AW'(h_eff - DW'(1));
					tlg_pkg::KIND_TOGGLE, tlg_pkg::KIND_READ: raddr = AW'(cmd.row);
					default: raddr = '0;
				endcase
			end
			S_RWAIT: begin
				we = (kind_q != tlg_pkg::KIND_READ);
			end
			S_TLAST: begin
				raddr = '0;
			end
			S_TFIRST: begin
				raddr = AW'(1);
			end
			S_TROW: begin
				raddr = r_q + AW'(2);
				we    = 1'b1;
				wdata = new_row;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	tlg_ram #(
		.WIDTH(MAX_DIM),
		.DEPTH(MAX_DIM)
	) u_grid (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_INIT;
			r_q      <= '0;
			cfg_w_q  <= tlg_pkg::DIM_RESET;
			cfg_h_q  <= tlg_pkg::DIM_RESET;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				if (cfg_idx == tlg_pkg::CFG_WIDTH) begin
					cfg_w_q <= cfg_data;
				end else begin
					cfg_h_q <= cfg_data;
				end
			end
			case (state_q)
				S_INIT: begin
					r_q <= r_q + AW'(1);
					if (r_q == AW'(MAX_DIM - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						w_q    <= w_eff;
						h_q    <= h_eff;
						kind_q <= cmd.kind;
						col_q  <= AW'(cmd.col);
						r_q    <= '0;
						case (cmd.kind)
							tlg_pkg::KIND_TICK: begin
								state_q <= S_TLAST;
							end
							tlg_pkg::KIND_CLEAR: begin
								end_q   <= AW'(h_eff - DW'(1));
								state_q <= S_RWAIT;
							end
							tlg_pkg::KIND_CROSS: begin
								end_q   <= AW'(s_eff - DW'(1));
								state_q <= S_RWAIT;
							end
							tlg_pkg::KIND_TOGGLE, tlg_pkg::KIND_READ: begin
								if (bad_in) begin
									done_q   <= 1'b1;
									result_q <= '{cell_alive: 1'b0, bad_coord: 1'b1};
								end else begin
									r_q     <= AW'(cmd.row);
									end_q   <= AW'(cmd.row);
									state_q <= S_RWAIT;
								end
							end
							default: begin
								done_q   <= 1'b1;
								result_q <= '0;
							end
						endcase
					end
				end
				S_RWAIT: begin
					if (r_q == end_q) begin
						done_q   <= 1'b1;
						result_q <= '{cell_alive: (kind_q == tlg_pkg::KIND_TOGGLE
							|| kind_q == tlg_pkg::KIND_READ) && mod_row[col_q],
							bad_coord: 1'b0};
						state_q  <= S_IDLE;
					end else begin
						r_q <= r_q + AW'(1);
					end
				end
				S_TLAST: begin
					last_q  <= rdata;
					state_q <= S_TFIRST;
				end
				S_TFIRST: begin
					first_q <= rdata;
					cur_q   <= rdata;
					state_q <= S_TROW;
				end
				S_TROW: begin
					prev_q <= cur_q;
					cur_q  <= below;
					if (r_q == AW'(h_q - DW'(1))) begin
						done_q   <= 1'b1;
						result_q <= '0;
						state_q  <= S_IDLE;
					end else begin
						r_q <= r_q + AW'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule
